>>> hw/rtl/cgavt_pkg.sv
// ----------------------------------------------------------------------------
// cgavt_pkg
// Types and constants shared by the CGA video timing generator modules.
// ----------------------------------------------------------------------------
package cgavt_pkg;

  localparam int COL_W = 12;
  localparam int ROW_W = 10;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // floor(x / 3) for x < 4096 as (x * 2731) >> 13
  localparam logic [11:0] DIV3_MUL   = 12'd2731;
  localparam int          DIV3_SHIFT = 13;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_LINE_PERIOD     = 3'd0,
    REG_HSYNC_WIDTH     = 3'd1,
    REG_LEFT_MARGIN     = 3'd2,
    REG_PIXEL_REPEAT    = 3'd3,
    REG_VISIBLE_ROWS    = 3'd4,
    REG_VSYNC_START_ROW = 3'd5,
    REG_VSYNC_ROWS      = 3'd6,
    REG_LAST_ROW        = 3'd7
  } reg_e;

  localparam logic [11:0] RST_LINE_PERIOD     = 12'd910;
  localparam logic [7:0]  RST_HSYNC_WIDTH     = 8'd64;
  localparam logic [9:0]  RST_LEFT_MARGIN     = 10'd110;
  localparam logic [2:0]  RST_PIXEL_REPEAT    = 3'd2;
  localparam logic [8:0]  RST_VISIBLE_ROWS    = 9'd200;
  localparam logic [9:0]  RST_VSYNC_START_ROW = 10'd225;
  localparam logic [3:0]  RST_VSYNC_ROWS      = 4'd3;
  localparam logic [9:0]  RST_LAST_ROW        = 10'd262;

  typedef struct packed {
    logic [11:0] line_period;
    logic [7:0]  hsync_width;
    logic [9:0]  left_margin;
    logic [2:0]  pixel_repeat;
    logic [8:0]  visible_rows;
    logic [9:0]  vsync_start_row;
    logic [3:0]  vsync_rows;
    logic [9:0]  last_row;
  } cfg_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] write_row;
    logic [7:0] write_col;
    logic [3:0] write_color;
  } in_item_t;

  typedef struct packed {
    logic       hsync;
    logic       vsync;
    logic [3:0] color;
    logic       frame_pulse;
    logic [9:0] current_row;
  } out_item_t;

  // One queued command. For a write, row/col hold the store position.
  // For a tick, col holds the image offset until it becomes the pixel index.
  typedef struct packed {
    op_e              op;
    logic             hsync;
    logic             vsync;
    logic             frame_pulse;
    logic             image;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [2:0]       rep;
    logic [3:0]       color;
    logic             wr_ok;
  } cmd_t;

endpackage

>>> hw/rtl/cgavt_ram.sv
// ----------------------------------------------------------------------------
// cgavt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cgavt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/cgavt_front.sv
// ----------------------------------------------------------------------------
// cgavt_front
// Column and row counters; classifies each accepted item into a command.
// ----------------------------------------------------------------------------
module cgavt_front #(
  parameter int FB_COLS = 256,
  parameter int FB_ROWS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cgavt_pkg::cfg_t     cfg,
  input  logic                accept,
  input  cgavt_pkg::in_item_t item,
  output logic                push,
  output cgavt_pkg::cmd_t     cmd
);

  logic [cgavt_pkg::COL_W-1:0] col_r, col_nxt;
  logic [cgavt_pkg::ROW_W-1:0] row_r, row_nxt;

  logic [cgavt_pkg::ROW_W-1:0] row_cur;
  logic [cgavt_pkg::ROW_W:0]   vs_end;
  logic                        in_vs;
  logic                        hs;
  logic [cgavt_pkg::COL_W-1:0] img_start;
  logic [cgavt_pkg::COL_W:0]   col_inc;
  logic [2:0]                  rep;
  logic                        is_tick;

  assign is_tick = (cgavt_pkg::op_e'(item.operation) == cgavt_pkg::OP_TICK);

  always_comb begin
    if (col_r == '0) begin
      row_cur = (row_r >= cfg.last_row) ? '0 : row_r + 10'd1;
    end else begin
      row_cur = row_r;
    end
    vs_end    = {1'b0, cfg.vsync_start_row} + 11'(cfg.vsync_rows);
    in_vs     = (row_cur >= cfg.vsync_start_row) && ({1'b0, row_cur} < vs_end);
    hs        = (col_r < {4'd0, cfg.hsync_width});
    img_start = {4'd0, cfg.hsync_width} + {2'd0, cfg.left_margin};
    col_inc   = {1'b0, col_r} + 13'd1;
    if (cfg.pixel_repeat == 3'd0) begin
      rep = 3'd1;
    end else if (cfg.pixel_repeat > 3'd4) begin
      rep = 3'd4;
    end else begin
      rep = cfg.pixel_repeat;
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept && is_tick) begin
      row_nxt = row_cur;
      col_nxt = (col_inc >= {1'b0, cfg.line_period}) ? '0 : col_inc[cgavt_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= cgavt_pkg::RST_LAST_ROW;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    push = accept;
    cmd  = '0;
    if (is_tick) begin
      cmd.op          = cgavt_pkg::OP_TICK;
      cmd.hsync       = hs;
      cmd.vsync       = in_vs;
      cmd.frame_pulse = !hs && in_vs && (col_r == {4'd0, cfg.hsync_width}) &&
                        (row_cur == cfg.vsync_start_row);
      cmd.image       = !hs && !in_vs && (row_cur < {1'b0, cfg.visible_rows}) &&
                        (32'(row_cur) < FB_ROWS) && (col_r >= img_start);
      cmd.row         = row_cur;
      cmd.col         = col_r - img_start;
      cmd.rep         = rep;
    end else begin
      cmd.op    = cgavt_pkg::OP_WRITE;
      cmd.row   = {2'd0, item.write_row};
      cmd.col   = {4'd0, item.write_col};
      cmd.color = item.write_color;
      cmd.wr_ok = (32'(item.write_row) < FB_ROWS) && (32'(item.write_col) < FB_COLS);
    end
  end

endmodule

>>> hw/rtl/cgavt_fifo.sv
// ----------------------------------------------------------------------------
// cgavt_fifo
// Short command queue between the counter front end and the pixel back end.
// ----------------------------------------------------------------------------
module cgavt_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cgavt_pkg::cmd_t push_cmd,
  input  logic            pop,
  output cgavt_pkg::cmd_t head,
  output logic            empty,
  output logic            full
);

  cgavt_pkg::cmd_t                 slot_r [cgavt_pkg::Q_DEPTH];
  logic [cgavt_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [cgavt_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [cgavt_pkg::Q_PTR_W:0]     count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (cgavt_pkg::Q_PTR_W + 1)'(cgavt_pkg::Q_DEPTH));
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (cgavt_pkg::Q_PTR_W + 1)'(push) - (cgavt_pkg::Q_PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue push while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("queue pop while empty");

endmodule

>>> hw/rtl/cgavt_back.sv
// ----------------------------------------------------------------------------
// cgavt_back
// Pixel pipeline: pixel index, frame store access and the result register.
// ----------------------------------------------------------------------------
module cgavt_back #(
  parameter int FB_COLS = 256,
  parameter int FB_ROWS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cgavt_pkg::cmd_t      head,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cgavt_pkg::out_item_t out_data
);

  localparam int DEPTH = FB_COLS * FB_ROWS;
  localparam int AW    = $clog2(DEPTH);

  logic                        en;
  logic                        s1_valid_r, s2_valid_r, s3_valid_r;
  cgavt_pkg::cmd_t             s1_cmd_r, s2_cmd_r, s2_cmd_nxt;
  logic [23:0]                 prod;
  logic [cgavt_pkg::COL_W-1:0] pix;
  logic                        in_range;
  logic [AW-1:0]               addr;
  logic                        ram_we, ram_re;
  logic [3:0]                  ram_rdata;
  logic                        s3_hs_r, s3_vs_r, s3_fp_r, s3_show_r;
  logic [cgavt_pkg::ROW_W-1:0] s3_row_r;

  assign en  = !s3_valid_r || !out_stall;
  assign pop = en && !q_empty;

  always_comb begin
    prod = {12'd0, s1_cmd_r.col} * {12'd0, cgavt_pkg::DIV3_MUL};
    case (s1_cmd_r.rep)
      3'd2:    pix = s1_cmd_r.col >> 1;
      3'd3:    pix = 12'(prod >> cgavt_pkg::DIV3_SHIFT);
      3'd4:    pix = s1_cmd_r.col >> 2;
      default: pix = s1_cmd_r.col;
    endcase
    s2_cmd_nxt = s1_cmd_r;
    if (s1_cmd_r.op == cgavt_pkg::OP_TICK) begin
      s2_cmd_nxt.col = pix;
    end
  end

  always_comb begin
    in_range = (32'(s2_cmd_r.col) < FB_COLS);
    addr     = AW'(32'(s2_cmd_r.row) * FB_COLS + 32'(s2_cmd_r.col));
    ram_we   = en && s2_valid_r && (s2_cmd_r.op == cgavt_pkg::OP_WRITE) && s2_cmd_r.wr_ok;
    ram_re   = en && s2_valid_r && (s2_cmd_r.op == cgavt_pkg::OP_TICK) &&
               s2_cmd_r.image && in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= pop;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r && (s2_cmd_r.op == cgavt_pkg::OP_TICK);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r  <= head;
      s2_cmd_r  <= s2_cmd_nxt;
      s3_hs_r   <= s2_cmd_r.hsync;
      s3_vs_r   <= s2_cmd_r.vsync;
      s3_fp_r   <= s2_cmd_r.frame_pulse;
      s3_row_r  <= s2_cmd_r.row;
      s3_show_r <= s2_cmd_r.image && in_range;
    end
  end

  cgavt_ram #(
    .WIDTH (4),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (s2_cmd_r.color),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_valid            = s3_valid_r;
    out_data.hsync       = s3_hs_r;
    out_data.vsync       = s3_vs_r;
    out_data.color       = s3_show_r ? ram_rdata : 4'd0;
    out_data.frame_pulse = s3_fp_r;
    out_data.current_row = s3_row_r;
  end

  a_black_in_sync : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.color != 4'd0) |-> !out_data.hsync && !out_data.vsync)
    else $error("color shown during sync");

  a_pulse_in_vsync : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_pulse |-> out_data.vsync && !out_data.hsync)
    else $error("frame pulse outside vsync");

  a_one_access : assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re)) else $error("store read and write in one cycle");

endmodule

>>> hw/rtl/cga_video_timing_generator.sv
// ----------------------------------------------------------------------------
// cga_video_timing_generator
// A tick passes the queue and registers s1, s2, s3; its result comes from s3.
// Throughput: one item per cycle while in_stall is low; writes give no result.
// Back pressure on out_stall fills a 4-entry queue, then raises in_stall.
// Reset: registers take their defaults, the row counter sits on row 262 so
// the first tick opens row 0; the frame store is not cleared.
// ----------------------------------------------------------------------------
module cga_video_timing_generator #(
  parameter int FB_COLS = 256,
  parameter int FB_ROWS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cgavt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cgavt_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cgavt_pkg::cfg_t  cfg_r;
  cgavt_pkg::reg_e  reg_sel;
  logic             cfg_we;
  logic             in_accept;
  logic             push, pop, q_empty, q_full;
  cgavt_pkg::cmd_t  push_cmd, head;

  assign pready  = 1'b1;
  assign reg_sel = cgavt_pkg::reg_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_period     <= cgavt_pkg::RST_LINE_PERIOD;
      cfg_r.hsync_width     <= cgavt_pkg::RST_HSYNC_WIDTH;
      cfg_r.left_margin     <= cgavt_pkg::RST_LEFT_MARGIN;
      cfg_r.pixel_repeat    <= cgavt_pkg::RST_PIXEL_REPEAT;
      cfg_r.visible_rows    <= cgavt_pkg::RST_VISIBLE_ROWS;
      cfg_r.vsync_start_row <= cgavt_pkg::RST_VSYNC_START_ROW;
      cfg_r.vsync_rows      <= cgavt_pkg::RST_VSYNC_ROWS;
      cfg_r.last_row        <= cgavt_pkg::RST_LAST_ROW;
    end else if (cfg_we) begin
      unique case (reg_sel)
        cgavt_pkg::REG_LINE_PERIOD:     cfg_r.line_period     <= pwdata[11:0];
        cgavt_pkg::REG_HSYNC_WIDTH:     cfg_r.hsync_width     <= pwdata[7:0];
        cgavt_pkg::REG_LEFT_MARGIN:     cfg_r.left_margin     <= pwdata[9:0];
        cgavt_pkg::REG_PIXEL_REPEAT:    cfg_r.pixel_repeat    <= pwdata[2:0];
        cgavt_pkg::REG_VISIBLE_ROWS:    cfg_r.visible_rows    <= pwdata[8:0];
        cgavt_pkg::REG_VSYNC_START_ROW: cfg_r.vsync_start_row <= pwdata[9:0];
        cgavt_pkg::REG_VSYNC_ROWS:      cfg_r.vsync_rows      <= pwdata[3:0];
        cgavt_pkg::REG_LAST_ROW:        cfg_r.last_row        <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      cgavt_pkg::REG_LINE_PERIOD:     prdata = 32'(cfg_r.line_period);
      cgavt_pkg::REG_HSYNC_WIDTH:     prdata = 32'(cfg_r.hsync_width);
      cgavt_pkg::REG_LEFT_MARGIN:     prdata = 32'(cfg_r.left_margin);
      cgavt_pkg::REG_PIXEL_REPEAT:    prdata = 32'(cfg_r.pixel_repeat);
      cgavt_pkg::REG_VISIBLE_ROWS:    prdata = 32'(cfg_r.visible_rows);
      cgavt_pkg::REG_VSYNC_START_ROW: prdata = 32'(cfg_r.vsync_start_row);
      cgavt_pkg::REG_VSYNC_ROWS:      prdata = 32'(cfg_r.vsync_rows);
      cgavt_pkg::REG_LAST_ROW:        prdata = 32'(cfg_r.last_row);
      default:                        prdata = '0;
    endcase
  end

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  cgavt_front #(
    .FB_COLS (FB_COLS),
    .FB_ROWS (FB_ROWS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (in_accept),
    .item   (in_data),
    .push   (push),
    .cmd    (push_cmd)
  );

  cgavt_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  cgavt_back #(
    .FB_COLS (FB_COLS),
    .FB_ROWS (FB_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
